// ===== src/ray_wall_nearest_hit_defines.svh =====
// Assertion macros shared by the ray and wall nearest hit RTL.
// Users must have clk and arst_n in scope; no other dependencies.
`ifndef RAY_WALL_NEAREST_HIT_DEFINES_SVH
`define RAY_WALL_NEAREST_HIT_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define RWNH_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition holds in the cycle after the trigger.
`define RWNH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/rwnh_pkg.sv =====
// Shared types, codes and constants for the ray and wall nearest hit block.
// No dependencies; imported by the divider, the top level and the testbench.
`timescale 1ns / 1ps

package rwnh_pkg;

	// Sine and cosine are held as signed Q28 values.
	localparam int TRIG_BITS = 28;
	localparam logic [30:0] Q30_ONE = 31'h4000_0000;
	// pi/2 in Q30, scaled for a 14-bit quarter wave argument.
	localparam logic [30:0] HALF_TURN_Q30_X = 31'd1686629713;
	localparam int TAYLOR_TERMS = 5;

	localparam int DIV_NUM_W = 96;
	localparam int DIV_DEN_W = 64;
	localparam int DIV_QUO_W = 32;

	typedef enum logic [1:0] {
		STAT_STORED,
		STAT_DROPPED,
		STAT_HIT,
		STAT_MISS
	} status_t;

	typedef enum logic {
		MODE_ADD,
		MODE_RAY
	} mode_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_T_U,
		S_T_U2,
		S_T_DIV,
		S_T_QUO,
		S_T_MUL,
		S_T_FIN,
		S_W_RD,
		S_W_DIFF,
		S_W_M1,
		S_W_M2,
		S_W_M3,
		S_W_M4,
		S_W_M5,
		S_W_M6,
		S_W_CHK,
		S_W_TST,
		S_W_DWAIT,
		S_W_ADV,
		S_H_MX,
		S_H_RX,
		S_H_SX,
		S_H_SY,
		S_DONE
	} seq_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef struct packed {
		logic [32:0] mult;
		logic [5:0]  shift;
	} recip_t;

	// Reciprocals for the divisors of the nested Taylor evaluation, innermost
	// first (110, 72, 42, 20, 6). For any 32-bit x, (x * mult) >> shift is
	// exactly the floor of x over the divisor.
	function automatic recip_t taylor_recip(input logic [2:0] k);
		recip_t r;
		case (k)
			3'd0: r = '{mult: 33'd4997780127, shift: 6'd39};
			3'd1: r = '{mult: 33'd7635497416, shift: 6'd39};
			3'd2: r = '{mult: 33'd6544712071, shift: 6'd38};
			3'd3: r = '{mult: 33'd6871947674, shift: 6'd37};
			default: r = '{mult: 33'd5726623062, shift: 6'd35};
		endcase
		return r;
	endfunction

endpackage

// ===== src/ray_wall_nearest_hit.sv =====
// Ray and wall nearest hit engine: top level with wall table and sequencer.
// Depends on rwnh_pkg, rwnh_div and ray_wall_nearest_hit_defines.svh.
//
// Usage: one request channel (in_valid/in_ready) carries either an add-wall
// request (mode 0, wall_x1..wall_y2) or a ray request (mode 1, ray_x, ray_y,
// ray_angle). Each request yields exactly one result on the out_valid/out_ready
// channel: status, hit_distance, hit_x and hit_y. All coordinates are signed
// Q16.16 and the heading uses 65536 steps per turn.
// An add request goes straight from idle to the result. A ray request first
// evaluates sine and cosine: each of the five series terms takes a reciprocal
// multiply, a register stage and a product on the shared multiplier. It then
// visits every stored wall; for a wall that is hit, the 32-step divider
// dominates, unless the distance saturates and the divider takes no steps.
// The final hit point follows through S_H_MX, S_H_RX, S_H_SX and S_H_SY. One
// request is worked on at a time; in_ready is high only while the sequencer
// is idle.
// The result sits in an output register, so a new request can be accepted
// while the previous result waits for out_ready. If the receiver stalls
// longer, the finished result is held in the sequencer until the output
// register frees up.
// Reset empties the wall table (count to zero) and drops any pending result.
`timescale 1ns / 1ps
`include "ray_wall_nearest_hit_defines.svh"

module ray_wall_nearest_hit import rwnh_pkg::*; #(
	parameter int MAX_WALLS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [0:0]         mode,
	input  logic signed [31:0] wall_x1,
	input  logic signed [31:0] wall_y1,
	input  logic signed [31:0] wall_x2,
	input  logic signed [31:0] wall_y2,
	input  logic signed [31:0] ray_x,
	input  logic signed [31:0] ray_y,
	input  logic [15:0]        ray_angle,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [31:0]        hit_distance,
	output logic signed [31:0] hit_x,
	output logic signed [31:0] hit_y
);

	localparam int IDX_W = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
	localparam int CNT_W = $clog2(MAX_WALLS + 1);

	// Sequencer state.
	seq_state_t state_q, state_d;
	logic       phase_q;
	logic [2:0] k_q;

	// Request registers.
	logic [15:0]        ang_q;
	logic signed [31:0] ox_q;
	logic signed [31:0] oy_q;

	// Trig registers.
	logic [30:0]        u_q;
	logic [31:0]        u2_q;
	logic [30:0]        t_q;
	logic signed [31:0] sn_q;
	logic signed [31:0] cs_q;

	// Wall table.
	logic [127:0]     wall_mem [MAX_WALLS];
	logic [127:0]     rd_q;
	logic [IDX_W-1:0] wi_q;
	logic [CNT_W-1:0] count_q;
	logic             full;
	logic             last_c;

	// Per-wall datapath.
	logic signed [32:0] dx_q, dy_q, ex_q, ey_q;
	logic signed [67:0] p1_q;
	logic signed [63:0] den_q;
	logic signed [63:0] ns_q;
	logic signed [67:0] nt_q;
	logic               flip_q;
	logic               found_q;
	logic [31:0]        best_q;
	logic signed [39:0] off_q;

	// Shared multiplier.
	logic signed [33:0] mul_a, mul_b;
	logic signed [67:0] prod_c, prod_q;

	// Shared divider.
	logic                 div_start;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	div_stat_t            div_stat;
	logic [DIV_QUO_W-1:0] div_quo;

	// Result staging and output registers.
	status_t     res_status_q, out_status_q;
	logic [31:0] res_dist_q, out_dist_q;
	logic [31:0] res_x_q, out_x_q;
	logic [31:0] res_y_q, out_y_q;
	logic        out_valid_q;
	logic        out_load;
	logic        set_miss;

	// Combinational helpers.
	logic [15:0]        ang_a;
	logic [1:0]         quad;
	logic [14:0]        rr;
	logic [30:0]        u_c;
	logic [31:0]        val_c;
	recip_t             rcp_c;
	logic [30:0]        quo_c;
	logic [30:0]        t_c;
	logic [32:0]        rnd_c;
	logic [30:0]        v_c;
	logic signed [31:0] sin_c;
	logic signed [67:0] negnt_c;
	logic               ok_c;
	logic signed [67:0] half_c;
	logic signed [67:0] rsum_c;
	logic signed [39:0] round_c;
	logic               accept;

	function automatic logic [31:0] sat_add(input logic signed [31:0] org,
			input logic signed [39:0] off);
		logic signed [40:0] s;
		logic [31:0]        r;
		s = $signed({{9{org[31]}}, org}) + $signed({off[39], off});
		if (s > 41'sd2147483647) begin
			r = 32'h7FFF_FFFF;
		end else if (s < -41'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = s[31:0];
		end
		return r;
	endfunction

	function automatic logic [15:0] ray_angle_off(input logic [15:0] a);
		return a + 16'd16384;
	endfunction

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign full     = (count_q == CNT_W'(MAX_WALLS));
	assign last_c   = (CNT_W'(wi_q) + CNT_W'(1)) == count_q;
	assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready);

	// Quarter-wave reduction: cosine is the sine a quarter turn later.
	assign ang_a = phase_q ? (ray_angle_off(ang_q)) : ang_q;
	assign quad  = ang_a[15:14];
	assign rr    = quad[0] ? (15'd16384 - {1'b0, ang_a[13:0]}) : {1'b0, ang_a[13:0]};
	assign u_c   = prod_q[44:14];
	assign val_c = prod_q[61:30];
	// Series division by a constant is a multiply by its reciprocal and a shift.
	assign rcp_c = taylor_recip(k_q);
	assign quo_c = 31'(prod_q >> rcp_c.shift);
	assign t_c   = Q30_ONE - quo_c;
	assign rnd_c = {1'b0, prod_q[61:30]} + 33'd2;
	assign v_c   = rnd_c[32:2];
	assign sin_c = quad[1] ? -$signed({1'b0, v_c}) : $signed({1'b0, v_c});

	// Wall acceptance after the denominator has been made positive.
	assign negnt_c = flip_q ? nt_q : -nt_q;
	assign ok_c    = (den_q != 64'sd0) && !ns_q[63] && (ns_q <= den_q) && !negnt_c[67];

	// Hit point offset, halves rounded away from zero.
	assign half_c  = 68'sd1 <<< (TRIG_BITS - 1);
	assign rsum_c  = prod_q + (prod_q[67] ? (half_c - 68'sd1) : half_c);
	assign round_c = rsum_c[67:TRIG_BITS];

	assign prod_c = mul_a * mul_b;

	always_comb begin
		state_d   = state_q;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		set_miss  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = (mode == MODE_ADD) ? S_DONE : S_T_U;
				end
			end
			S_T_U: begin
				mul_a   = $signed({19'b0, rr});
				mul_b   = $signed({3'b0, HALF_TURN_Q30_X});
				state_d = S_T_U2;
			end
			S_T_U2: begin
				mul_a   = $signed({3'b0, u_c});
				mul_b   = $signed({3'b0, u_c});
				state_d = S_T_DIV;
			end
			S_T_DIV: begin
				mul_a   = $signed({2'b0, val_c});
				mul_b   = $signed({1'b0, rcp_c.mult});
				state_d = S_T_QUO;
			end
			S_T_QUO: state_d = S_T_MUL;
			S_T_MUL: begin
				mul_b = $signed({3'b0, t_q});
				if (k_q == 3'(TAYLOR_TERMS - 1)) begin
					mul_a   = $signed({3'b0, u_q});
					state_d = S_T_FIN;
				end else begin
					mul_a   = $signed({2'b0, u2_q});
					state_d = S_T_DIV;
				end
			end
			S_T_FIN: begin
				if (!phase_q) begin
					state_d = S_T_U;
				end else if (count_q == '0) begin
					set_miss = 1'b1;
					state_d  = S_DONE;
				end else begin
					state_d = S_W_RD;
				end
			end
			S_W_RD:   state_d = S_W_DIFF;
			S_W_DIFF: state_d = S_W_M1;
			S_W_M1: begin
				mul_a   = {dx_q[32], dx_q};
				mul_b   = {{2{sn_q[31]}}, sn_q};
				state_d = S_W_M2;
			end
			S_W_M2: begin
				mul_a   = {dy_q[32], dy_q};
				mul_b   = {{2{cs_q[31]}}, cs_q};
				state_d = S_W_M3;
			end
			S_W_M3: begin
				mul_a   = {ex_q[32], ex_q};
				mul_b   = {{2{sn_q[31]}}, sn_q};
				state_d = S_W_M4;
			end
			S_W_M4: begin
				mul_a   = {ey_q[32], ey_q};
				mul_b   = {{2{cs_q[31]}}, cs_q};
				state_d = S_W_M5;
			end
			S_W_M5: begin
				mul_a   = {dx_q[32], dx_q};
				mul_b   = {ey_q[32], ey_q};
				state_d = S_W_M6;
			end
			S_W_M6: begin
				mul_a   = {dy_q[32], dy_q};
				mul_b   = {ex_q[32], ex_q};
				state_d = S_W_CHK;
			end
			S_W_CHK: state_d = S_W_TST;
			S_W_TST: begin
				if (ok_c) begin
					div_start = 1'b1;
					div_num   = {2'b00, negnt_c[65:0], {TRIG_BITS{1'b0}}};
					div_den   = den_q;
					state_d   = S_W_DWAIT;
				end else begin
					state_d = S_W_ADV;
				end
			end
			S_W_DWAIT: begin
				if (div_stat.done) begin
					state_d = S_W_ADV;
				end
			end
			S_W_ADV: begin
				if (!last_c) begin
					state_d = S_W_RD;
				end else if (found_q) begin
					state_d = S_H_MX;
				end else begin
					set_miss = 1'b1;
					state_d  = S_DONE;
				end
			end
			S_H_MX: begin
				mul_a   = $signed({2'b0, best_q});
				mul_b   = {{2{cs_q[31]}}, cs_q};
				state_d = S_H_RX;
			end
			S_H_RX: begin
				mul_a   = $signed({2'b0, best_q});
				mul_b   = {{2{sn_q[31]}}, sn_q};
				state_d = S_H_SX;
			end
			S_H_SX: state_d = S_H_SY;
			S_H_SY: state_d = S_DONE;
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && (mode == MODE_ADD) && !full) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Wall table: written on add, read one wall at a time by the sequencer.
	always_ff @(posedge clk) begin
		if (accept && (mode == MODE_ADD) && !full) begin
			wall_mem[count_q[IDX_W-1:0]] <= {wall_y2, wall_x2, wall_y1, wall_x1};
		end
		rd_q <= wall_mem[wi_q];
	end

	always_ff @(posedge clk) begin
		prod_q <= prod_c;
		if (out_load) begin
			out_status_q <= res_status_q;
			out_dist_q   <= res_dist_q;
			out_x_q      <= res_x_q;
			out_y_q      <= res_y_q;
		end
		if (set_miss) begin
			res_status_q <= STAT_MISS;
			res_dist_q   <= '1;
			res_x_q      <= '0;
			res_y_q      <= '0;
		end
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ang_q   <= ray_angle;
					ox_q    <= ray_x;
					oy_q    <= ray_y;
					phase_q <= 1'b0;
					k_q     <= '0;
					found_q <= 1'b0;
					best_q  <= '1;
					wi_q    <= '0;
					if (mode == MODE_ADD) begin
						res_status_q <= full ? STAT_DROPPED : STAT_STORED;
						res_dist_q   <= '0;
						res_x_q      <= '0;
						res_y_q      <= '0;
					end
				end
			end
			S_T_U2: u_q <= u_c;
			S_T_DIV: begin
				if (k_q == '0) begin
					u2_q <= val_c;
				end
			end
			S_T_QUO: t_q <= t_c;
			S_T_MUL: begin
				if (k_q != 3'(TAYLOR_TERMS - 1)) begin
					k_q <= k_q + 3'd1;
				end
			end
			S_T_FIN: begin
				if (!phase_q) begin
					sn_q <= sin_c;
				end else begin
					cs_q <= sin_c;
				end
				phase_q <= 1'b1;
				k_q     <= '0;
			end
			S_W_DIFF: begin
				dx_q <= $signed({rd_q[95], rd_q[95:64]}) - $signed({rd_q[31], rd_q[31:0]});
				dy_q <= $signed({rd_q[127], rd_q[127:96]}) - $signed({rd_q[63], rd_q[63:32]});
				ex_q <= $signed({ox_q[31], ox_q}) - $signed({rd_q[31], rd_q[31:0]});
				ey_q <= $signed({oy_q[31], oy_q}) - $signed({rd_q[63], rd_q[63:32]});
			end
			S_W_M2: p1_q <= prod_q;
			S_W_M3: den_q <= 64'(p1_q - prod_q);
			S_W_M4: p1_q <= prod_q;
			S_W_M5: ns_q <= 64'(p1_q - prod_q);
			S_W_M6: p1_q <= prod_q;
			S_W_CHK: begin
				nt_q   <= p1_q - prod_q;
				flip_q <= den_q[63];
				den_q  <= den_q[63] ? -den_q : den_q;
				ns_q   <= den_q[63] ? -ns_q : ns_q;
			end
			S_W_DWAIT: begin
				// Strict compare keeps the earliest wall on equal distances.
				if (div_stat.done && (!found_q || (div_quo < best_q))) begin
					best_q  <= div_quo;
					found_q <= 1'b1;
				end
			end
			S_W_ADV: begin
				if (!last_c) begin
					wi_q <= wi_q + IDX_W'(1);
				end
			end
			S_H_RX: off_q <= round_c;
			S_H_SX: begin
				res_x_q <= sat_add(ox_q, off_q);
				off_q   <= round_c;
			end
			S_H_SY: begin
				res_y_q      <= sat_add(oy_q, off_q);
				res_status_q <= STAT_HIT;
				res_dist_q   <= best_q;
			end
			default: begin
			end
		endcase
	end

	rwnh_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.stat   (div_stat),
		.quo    (div_quo)
	);

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign hit_distance = out_dist_q;
	assign hit_x        = out_x_q;
	assign hit_y        = out_y_q;

	`RWNH_ASSERT_NEXT(a_count_grows, accept && (mode == MODE_ADD) && !full, count_q == $past(count_q) + CNT_W'(1), "wall count did not advance on a stored wall")
	`RWNH_ASSERT_NOW(a_index_in_table, state_q == S_W_RD, CNT_W'(wi_q) < count_q, "wall index beyond stored walls")
	`RWNH_ASSERT_NOW(a_div_free, div_start, !div_stat.busy, "divider restarted while busy")
	`RWNH_ASSERT_NOW(a_miss_clean, out_valid_q && (out_status_q == STAT_MISS), (out_x_q == '0) && (out_y_q == '0) && (out_dist_q == '1), "miss result carries a hit point")

endmodule

// ===== src/rwnh_div.sv =====
// Shared restoring divider: 96-bit dividend by 64-bit divisor, 32-bit quotient
// that saturates to all ones. Depends on rwnh_pkg.
`timescale 1ns / 1ps

module rwnh_div import rwnh_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output div_stat_t            stat,
	output logic [DIV_QUO_W-1:0] quo
);

	localparam int CNT_W = $clog2(DIV_QUO_W);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_QUO_W-1:0] lo_q;
	logic [DIV_QUO_W-1:0] quo_q;
	logic [DIV_DEN_W:0]   trial;
	logic [DIV_DEN_W:0]   diff;
	logic                 take;
	logic                 sat;

	// The quotient overflows exactly when the upper dividend part reaches the divisor.
	assign sat   = num[DIV_NUM_W-1:DIV_QUO_W] >= den;
	assign trial = {rem_q, lo_q[DIV_QUO_W-1]};
	assign take  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= '0;
				if (sat) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_QUO_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= num[DIV_NUM_W-1:DIV_QUO_W];
			lo_q  <= num[DIV_QUO_W-1:0];
			quo_q <= sat ? '1 : '0;
		end else if (busy_q) begin
			rem_q <= take ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
			lo_q  <= {lo_q[DIV_QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[DIV_QUO_W-2:0], take};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = quo_q;

endmodule

// ===== tb/tb_ray_wall_nearest_hit.sv =====
// Self-checking testbench for ray_wall_nearest_hit: wall adds and ray casts.
// A built-in fixed-point predictor computes each expected result on request acceptance.
// Depends on rwnh_pkg and the ray_wall_nearest_hit RTL.
`timescale 1ns / 1ps

module tb_ray_wall_nearest_hit;
	import rwnh_pkg::*;

	localparam int WALL_SLOTS = 64;
	localparam int N_RANDOM = 1380;
	localparam int STALL_LIMIT = 20000;
	localparam int HOLD_CYCLES = 3000;
	localparam logic signed [31:0] UNIT = 32'sd65536;
	localparam logic signed [31:0] CMAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] CMIN = 32'sh8000_0000;
	localparam logic [31:0] NO_HIT_DIST = 32'hFFFF_FFFF;

	typedef struct packed {
		status_t     st;
		logic [31:0] distance;
		logic [31:0] hx;
		logic [31:0] hy;
	} hit_res_t;

	typedef struct {
		mode_t              md;
		logic signed [31:0] x1, y1, x2, y2, rx, ry;
		logic [15:0]        ang;
		logic               fixed;
		hit_res_t           res;
	} ray_req_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [0:0]         mode = 1'b0;
	logic signed [31:0] wall_x1 = '0, wall_y1 = '0, wall_x2 = '0, wall_y2 = '0;
	logic signed [31:0] ray_x = '0, ray_y = '0;
	logic [15:0]        ray_angle = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         status;
	logic [31:0]        hit_distance;
	logic signed [31:0] hit_x, hit_y;

	ray_wall_nearest_hit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.mode(mode), .wall_x1(wall_x1), .wall_y1(wall_y1),
		.wall_x2(wall_x2), .wall_y2(wall_y2),
		.ray_x(ray_x), .ray_y(ray_y), .ray_angle(ray_angle),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .hit_distance(hit_distance), .hit_x(hit_x), .hit_y(hit_y)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Predictor state: our own copy of the wall table.
	longint  tbl_x1 [WALL_SLOTS];
	longint  tbl_y1 [WALL_SLOTS];
	longint  tbl_x2 [WALL_SLOTS];
	longint  tbl_y2 [WALL_SLOTS];
	int      walls_held = 0;

	hit_res_t pending_results[$];
	ray_req_t directed_reqs[$];
	ray_req_t cur_req;

	int errors = 0;
	int n_stored = 0, n_dropped = 0, n_hits = 0, n_misses = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 0, recv_stall_pct = 0;
	bit hold_req = 1'b0;
	int hold_left = 0;

	// Quarter-wave sine in unsigned Q2.30 by a nested odd Taylor series; every
	// product is truncated so that the result matches the hardware bit for bit.
	function automatic longint unsigned quarter_wave(longint unsigned r);
		longint unsigned u, u2, t, one;
		one = 64'd1 << 30;
		u = (r * 64'd1686629713) >> 14;
		u2 = (u * u) >> 30;
		t = one - u2 / 110;
		t = one - ((u2 * t) >> 30) / 72;
		t = one - ((u2 * t) >> 30) / 42;
		t = one - ((u2 * t) >> 30) / 20;
		t = one - ((u2 * t) >> 30) / 6;
		return (u * t) >> 30;
	endfunction

	// Signed sine in Q28 for a heading where 65536 is one full turn.
	function automatic longint heading_sine(logic [15:0] a);
		longint unsigned m;
		longint v;
		m = a[14] ? quarter_wave(64'd16384 - a[13:0]) : quarter_wave(a[13:0]);
		v = longint'((m + 2) >> 2);
		return a[15] ? -v : v;
	endfunction

	// Origin plus distance times direction, rounded half away from zero and
	// clamped to the signed 32-bit coordinate range.
	function automatic logic [31:0] hit_point(longint origin, logic [31:0] span, longint dir);
		longint p, off, v;
		p = longint'({32'd0, span}) * dir;
		if (p >= 0)
			off = (p + (64'sd1 <<< 27)) >>> 28;
		else
			off = -((-p + (64'sd1 <<< 27)) >>> 28);
		v = origin + off;
		if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
		if (v < -64'sh8000_0000) v = -64'sh8000_0000;
		return v[31:0];
	endfunction

	// Applies one request to the predictor state and returns its result.
	function automatic hit_res_t cast_or_store(ray_req_t q);
		hit_res_t r;
		longint ox, oy, sn, cs, dx, dy, ex, ey, den, ns;
		logic signed [127:0] nt, a, b, c, d;
		logic [127:0] num, quo;
		logic [31:0] cand, best;
		bit found;
		r = '{st: STAT_STORED, distance: '0, hx: '0, hy: '0};
		if (q.md == MODE_ADD) begin
			if (walls_held < WALL_SLOTS) begin
				tbl_x1[walls_held] = q.x1;
				tbl_y1[walls_held] = q.y1;
				tbl_x2[walls_held] = q.x2;
				tbl_y2[walls_held] = q.y2;
				walls_held++;
			end else begin
				r.st = STAT_DROPPED;
			end
			return r;
		end
		ox = q.rx;
		oy = q.ry;
		sn = heading_sine(q.ang);
		cs = heading_sine(q.ang + 16'd16384);
		found = 1'b0;
		best = NO_HIT_DIST;
		for (int i = 0; i < walls_held; i++) begin
			dx = tbl_x2[i] - tbl_x1[i];
			dy = tbl_y2[i] - tbl_y1[i];
			ex = ox - tbl_x1[i];
			ey = oy - tbl_y1[i];
			den = dx * sn - dy * cs;
			ns = ex * sn - ey * cs;
			// A parallel or zero-length wall has no crossing.
			if (den == 0) continue;
			a = dx; b = ey; c = dy; d = ex;
			nt = a * b - c * d;
			if (den < 0) begin
				den = -den;
				ns = -ns;
				nt = -nt;
			end
			if (ns < 0 || ns > den) continue;
			// A positive cross product puts the wall behind the origin.
			if (nt > 0) continue;
			num = (-nt) <<< 28;
			quo = num / {64'd0, den};
			cand = (quo > 128'hFFFF_FFFF) ? NO_HIT_DIST : quo[31:0];
			// Strict compare: on a tie the earliest stored wall stays.
			if (!found || cand < best) begin
				found = 1'b1;
				best = cand;
			end
		end
		if (!found) begin
			r.st = STAT_MISS;
			r.distance = NO_HIT_DIST;
			return r;
		end
		r.st = STAT_HIT;
		r.distance = best;
		r.hx = hit_point(ox, best, cs);
		r.hy = hit_point(oy, best, sn);
		return r;
	endfunction

	function automatic logic signed [31:0] pick_coord();
		// Mostly coordinates near the origin so that rays actually hit walls.
		if ($urandom_range(99) < 15)
			return $urandom;
		return $signed($urandom_range(0, 2 * 64 * 65536)) - 64 * 65536;
	endfunction

	task automatic add_row(mode_t md, logic signed [31:0] x1, y1, x2, y2, rx, ry,
			logic [15:0] ang, logic fixed, hit_res_t res);
		ray_req_t q;
		q = '{md: md, x1: x1, y1: y1, x2: x2, y2: y2, rx: rx, ry: ry, ang: ang,
			fixed: fixed, res: res};
		directed_reqs = {directed_reqs, q};
	endtask

	// Presents one request and holds it until the block takes it.
	task automatic offer(ray_req_t q);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cur_req <= q;
		in_valid <= 1'b1;
		mode <= q.md;
		wall_x1 <= q.x1;
		wall_y1 <= q.y1;
		wall_x2 <= q.x2;
		wall_y2 <= q.y2;
		ray_x <= q.rx;
		ray_y <= q.ry;
		ray_angle <= q.ang;
		do @(posedge clk); while (!in_ready);
	endtask

	// Receiver: random stalls, plus one long hold-off counted here.
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Scoreboard. The result is popped before the new request is pushed, since
	// a result leaving in the same cycle always belongs to an older request.
	always @(posedge clk) begin
		hit_res_t want, got;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got = '{st: status_t'(status), distance: hit_distance, hx: hit_x, hy: hit_y};
				if (pending_results.size() == 0) begin
					$display("%0t: result with no request outstanding: %p", $time, got);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (got.st != want.st) begin
						$display("%0t: status expected %s got %0d", $time, want.st.name(), status);
						errors++;
					end
					if (got.distance != want.distance) begin
						$display("%0t: hit_distance expected %h got %h", $time,
							want.distance, got.distance);
						errors++;
					end
					if (got.hx != want.hx) begin
						$display("%0t: hit_x expected %h got %h", $time, want.hx, got.hx);
						errors++;
					end
					if (got.hy != want.hy) begin
						$display("%0t: hit_y expected %h got %h", $time, want.hy, got.hy);
						errors++;
					end
				end
			end
			if (in_valid && in_ready) begin
				want = cast_or_store(cur_req);
				if (cur_req.fixed) want = cur_req.res;
				case (want.st)
					STAT_STORED: n_stored++;
					STAT_DROPPED: n_dropped++;
					STAT_HIT: n_hits++;
					default: n_misses++;
				endcase
				pending_results = {pending_results, want};
			end
			// Watchdog: a ray over a full table is the slowest request.
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
				$display("tb_ray_wall_nearest_hit: errors");
				$finish;
			end
		end
	end

	initial begin
		hit_res_t stored_res, miss_res, none;
		ray_req_t q;
		int phase;
		stored_res = '{st: STAT_STORED, distance: '0, hx: '0, hy: '0};
		miss_res = '{st: STAT_MISS, distance: NO_HIT_DIST, hx: '0, hy: '0};
		none = stored_res;

		// Directed requests. Fixed rows are read straight off the spec.
		add_row(MODE_RAY, 0, 0, 0, 0, 0, 0, 16'd0, 1'b1, miss_res);        // empty table
		add_row(MODE_ADD, 10 * UNIT, -10 * UNIT, 10 * UNIT, 10 * UNIT, 0, 0, 16'd0, 1'b1,
			stored_res);
		add_row(MODE_RAY, 0, 0, 0, 0, 0, 0, 16'd0, 1'b0, none);            // straight hit
		add_row(MODE_RAY, 0, 0, 0, 0, 0, 0, 16'd32768, 1'b1, miss_res);    // wall behind
		add_row(MODE_RAY, 0, 0, 0, 0, 0, 0, 16'd16384, 1'b1, miss_res);    // parallel
		add_row(MODE_ADD, 5 * UNIT, 5 * UNIT, 5 * UNIT, 5 * UNIT, 0, 0, 16'd0, 1'b1,
			stored_res);                                                    // zero length
		add_row(MODE_ADD, 10 * UNIT, -10 * UNIT, 10 * UNIT, 10 * UNIT, 0, 0, 16'd0, 1'b1,
			stored_res);                                                    // duplicate wall
		add_row(MODE_RAY, 0, 0, 0, 0, 0, 3 * UNIT, 16'd0, 1'b0, none);     // tie on distance
		add_row(MODE_RAY, 0, 0, 0, 0, 10 * UNIT, 0, 16'd0, 1'b0, none);    // origin on wall
		add_row(MODE_ADD, CMAX, CMIN, CMAX, CMAX, 0, 0, 16'd0, 1'b1, stored_res);
		add_row(MODE_RAY, 0, 0, 0, 0, CMIN, 20 * UNIT, 16'd0, 1'b0, none); // saturated
		add_row(MODE_RAY, 0, 0, 0, 0, CMAX, CMAX, 16'd49152, 1'b0, none);
		add_row(MODE_RAY, 0, 0, 0, 0, CMIN, CMIN, 16'hFFFF, 1'b0, none);
		add_row(MODE_ADD, CMIN, CMIN, CMAX, CMAX, 0, 0, 16'd0, 1'b1, stored_res);
		add_row(MODE_RAY, 0, 0, 0, 0, 0, 2 * UNIT, 16'd8192, 1'b0, none);
		add_row(MODE_RAY, 0, 0, 0, 0, -5 * UNIT, 0, 16'd57344, 1'b0, none);
		add_row(MODE_RAY, 0, 0, 0, 0, CMAX, CMIN, 16'd24576, 1'b0, none);
		add_row(MODE_ADD, CMAX, CMAX, CMIN, CMIN, -1, -1, 16'hFFFF, 1'b1, stored_res);
		add_row(MODE_RAY, -1, -1, -1, -1, -1, -1, 16'd40960, 1'b0, none);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_reqs[i]) offer(directed_reqs[i]);

		// Random requests: the table fills early, after which every add is
		// dropped and rays sweep the full table.
		for (int i = 0; i < N_RANDOM; i++) begin
			phase = i * 4 / N_RANDOM;
			send_idle_pct = (phase == 1) ? 60 : (phase == 3) ? 33 : 0;
			recv_stall_pct = (phase == 2) ? 60 : (phase == 3) ? 33 : 0;
			if (i == 300) hold_req = 1'b1;
			if (i == 600) begin
				in_valid <= 1'b0;
				wait (pending_results.size() == 0);
				@(posedge clk);
			end
			q.md = ($urandom_range(99) < ((i < 100) ? 60 : 40)) ? MODE_ADD : MODE_RAY;
			q.x1 = pick_coord();
			q.y1 = pick_coord();
			q.x2 = pick_coord();
			q.y2 = pick_coord();
			q.rx = pick_coord();
			q.ry = pick_coord();
			q.ang = $urandom_range(0, 65535);
			q.fixed = 1'b0;
			q.res = none;
			offer(q);
		end
		in_valid <= 1'b0;

		wait (pending_results.size() == 0);
		repeat (50) @(posedge clk);
		$display("Covered %0d walls stored, %0d dropped on a full table,", n_stored, n_dropped);
		$display("and %0d ray casts (%0d hits, %0d misses).", n_hits + n_misses, n_hits, n_misses);
		if (errors == 0)
			$display("tb_ray_wall_nearest_hit: clean");
		else
			$display("tb_ray_wall_nearest_hit: errors");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+src
src/rwnh_pkg.sv
src/rwnh_div.sv
src/ray_wall_nearest_hit.sv
tb/tb_ray_wall_nearest_hit.sv
